// ===== rtl/core/masked_byte_pattern_scanner_core_assert.svh =====
// Assertion macros for the scanner core, clocked on clk, quiet while in reset
`ifndef MASKED_BYTE_PATTERN_SCANNER_CORE_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SCANNER_CORE_ASSERT_SVH

// same-cycle implication
`define MBPS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MBPS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mbps_pkg.sv =====
package mbps_pkg;

  localparam int ADDR_W          = 64;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_IDX_W       = 3;
  localparam int PAT_BYTES       = 16;
  localparam int PAT_IDX_W       = $clog2(PAT_BYTES);
  localparam int LEN_W           = 5;
  localparam int DEF_MAX_PATTERN = 16;
  localparam int DEF_COUNT_BITS  = 33;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE     = 3'd0,
    REG_PAT_LO   = 3'd1,
    REG_PAT_HI   = 3'd2,
    REG_CARE     = 3'd3,
    REG_LEN      = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] match_address;
  } out_item_t;

  typedef struct packed {
    logic [8*PAT_BYTES-1:0] pattern;
    logic [PAT_BYTES-1:0]   care;
    logic [LEN_W-1:0]       len;
  } scan_cfg_t;

  // stage-two verdict handed to the output stage
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [ADDR_W-1:0] offset;
  } verdict_t;

endpackage

// ===== rtl/core/mbps_cell.sv =====
module mbps_cell #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                shift_en,
  input  logic [7:0]          byte_in,
  input  mbps_pkg::scan_cfg_t cfg,
  output logic [7:0]          byte_out,
  output logic                hit_out
);
  import mbps_pkg::*;

  localparam logic [LEN_W-1:0] POS = LEN_W'(IDX);

  logic [7:0]           byte_r;
  logic                 hit_r;
  logic                 hit_nxt;
  logic                 in_use;
  logic [LEN_W-1:0]     rev_idx;
  logic [PAT_IDX_W-1:0] pidx;
  logic [7:0]           pat_byte;

  // window entry IDX lines up with pattern byte len-1-IDX
  always_comb begin
    in_use   = POS < cfg.len;
    rev_idx  = LEN_W'(cfg.len - POS - LEN_W'(1));
    pidx     = rev_idx[PAT_IDX_W-1:0];
    pat_byte = cfg.pattern[8*pidx +: 8];
    hit_nxt  = !in_use || !cfg.care[pidx] || (byte_in == pat_byte);
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
      hit_r  <= hit_nxt;
    end
  end

  assign byte_out = byte_r;
  assign hit_out  = hit_r;

endmodule

// ===== rtl/core/mbps_resolve.sv =====
module mbps_resolve #(
  parameter int MAX_PATTERN = mbps_pkg::DEF_MAX_PATTERN,
  parameter int COUNT_BITS  = mbps_pkg::DEF_COUNT_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         s1_valid,
  input  logic                         s1_last,
  input  logic [COUNT_BITS-1:0]        count,
  input  logic [MAX_PATTERN-1:0]       hits,
  input  logic [mbps_pkg::LEN_W-1:0]   len,
  output mbps_pkg::verdict_t           verdict
);
  import mbps_pkg::*;

  logic                  reported_r;
  logic                  reported_nxt;
  verdict_t              verdict_r;
  verdict_t              verdict_nxt;
  logic [COUNT_BITS:0]   diff;
  logic                  len_ok;
  logic                  match;

  always_comb begin
    diff   = {1'b0, count} - (COUNT_BITS + 1)'(len);
    len_ok = (len != '0) && (len <= LEN_W'(MAX_PATTERN));
    match  = (&hits) && len_ok && !diff[COUNT_BITS];

    verdict_nxt  = '0;
    reported_nxt = reported_r;
    if (s1_valid) begin
      if (!reported_r) begin
        if (match) begin
          verdict_nxt.valid  = 1'b1;
          verdict_nxt.found  = 1'b1;
          verdict_nxt.offset = ADDR_W'(diff[COUNT_BITS-1:0]);
          reported_nxt       = 1'b1;
        end else if (s1_last) begin
          verdict_nxt.valid  = 1'b1;
        end
      end
      if (s1_last) begin
        reported_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reported_r <= 1'b0;
      verdict_r  <= '0;
    end else if (adv) begin
      reported_r <= reported_nxt;
      verdict_r  <= verdict_nxt;
    end
  end

  assign verdict = verdict_r;

endmodule

// ===== rtl/core/masked_byte_pattern_scanner_core.sv =====
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | in_item (data_byte, last_byte)
// out     | output    | out_valid/out_stall| out_item (found, match_address)
// cfg     | input     | cfg_we             | cfg_idx, cfg_wdata
//
// One byte per cycle unless stalled; a result passes the cell, verdict and output registers in turn.
// The row of window cells shifts once per request and registers its compare;
// stage two ands the cell hits and works out the offset, stage three adds the base.
// Stalls freeze the whole pipe, so in_stall follows out_stall while a result waits.
// Synchronous active-low reset clears configuration, counters and valids.
module masked_byte_pattern_scanner_core #(
  parameter int MAX_PATTERN = mbps_pkg::DEF_MAX_PATTERN,
  parameter int COUNT_BITS  = mbps_pkg::DEF_COUNT_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  mbps_pkg::in_item_t                in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output mbps_pkg::out_item_t               out_item,
  input  logic                              cfg_we,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import mbps_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [ADDR_W-1:0]      base_r;
  logic [63:0]            pat_lo_r;
  logic [63:0]            pat_hi_r;
  logic [PAT_BYTES-1:0]   care_r;
  logic [LEN_W-1:0]       len_r;
  scan_cfg_t              cfg;

  logic                   adv;
  logic                   accept;
  logic                   s1_valid_r;
  logic                   s1_last_r;
  logic [COUNT_BITS-1:0]  count_r;
  logic [COUNT_BITS-1:0]  count_nxt;
  logic [7:0]             chain [MAX_PATTERN+1];
  logic [MAX_PATTERN-1:0] hits;
  verdict_t               verdict;
  logic                   out_valid_r;
  out_item_t              out_item_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      pat_lo_r <= '0;
      pat_hi_r <= '0;
      care_r   <= '0;
      len_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_BASE:   base_r   <= cfg_wdata[ADDR_W-1:0];
        REG_PAT_LO: pat_lo_r <= cfg_wdata[63:0];
        REG_PAT_HI: pat_hi_r <= cfg_wdata[63:0];
        REG_CARE:   care_r   <= cfg_wdata[PAT_BYTES-1:0];
        REG_LEN:    len_r    <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.pattern = {pat_hi_r, pat_lo_r};
  assign cfg.care    = care_r;
  assign cfg.len     = len_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  // byte count restarts after the last byte of a range; saturates
  always_comb begin
    if (s1_last_r) begin
      count_nxt = COUNT_BITS'(1);
    end else if (count_r == COUNT_MAX) begin
      count_nxt = count_r;
    end else begin
      count_nxt = count_r + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_last_r  <= 1'b0;
      count_r    <= '0;
    end else begin
      if (adv) begin
        s1_valid_r <= in_valid;
      end
      if (accept) begin
        s1_last_r <= in_item.last_byte;
        count_r   <= count_nxt;
      end
    end
  end

  // window cells: stale entries past the count are never compared
  assign chain[0] = in_item.data_byte;

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    mbps_cell #(
      .IDX (j)
    ) u_cell (
      .clk      (clk),
      .shift_en (accept),
      .byte_in  (chain[j]),
      .cfg      (cfg),
      .byte_out (chain[j+1]),
      .hit_out  (hits[j])
    );
  end

  mbps_resolve #(
    .MAX_PATTERN (MAX_PATTERN),
    .COUNT_BITS  (COUNT_BITS)
  ) u_resolve (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .s1_valid (s1_valid_r),
    .s1_last  (s1_last_r),
    .count    (count_r),
    .hits     (hits),
    .len      (len_r),
    .verdict  (verdict)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= verdict.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r.found         <= verdict.found;
      out_item_r.match_address <= verdict.found ? (base_r + verdict.offset) : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `include "masked_byte_pattern_scanner_core_assert.svh"

  `MBPS_ASSERT_IMP(a_stall_follows_out, 1'b1, in_stall == (out_valid && out_stall), "in_stall mismatch")
  `MBPS_ASSERT_NXT(a_count_restart, accept && s1_last_r, count_r == COUNT_BITS'(1), "count not restarted")
  `MBPS_ASSERT_IMP(a_notfound_zero, out_valid && !out_item.found, out_item.match_address == '0, "address set on miss")

endmodule

// ===== tb/masked_byte_pattern_scanner_core_tb.sv =====
module masked_byte_pattern_scanner_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mbps_pkg::*;

  localparam int SPARE_IDX    = int'(REG_LEN) + 1;
  localparam int TOP_IDX      = 2 ** CFG_IDX_W - 1;
  localparam int RANDOM_ITEMS = 550;
  localparam int HOLD_CYCLES  = 100;

  typedef enum {FLOW, SOME_STALLS, MANY_STALLS} stall_mode_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  masked_byte_pattern_scanner_core DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // scanner state as the block should hold it
  logic [ADDR_W-1:0]         base_addr = '0;
  logic [63:0]               pat_lo    = '0;
  logic [63:0]               pat_hi    = '0;
  logic [PAT_BYTES-1:0]      care_bits = '0;
  logic [LEN_W-1:0]          pat_len   = '0;
  logic [7:0]                window [PAT_BYTES] = '{default: '0};
  logic [DEF_COUNT_BITS-1:0] seen_cnt  = '0;
  bit                        hit_done  = 1'b0;

  in_item_t  pending_bytes [$];
  out_item_t scan_verdicts [$];
  int        queued = 0;
  int        errors = 0;
  bit        hold_req = 1'b0;

  function automatic logic [7:0] pat_byte(int i);
    logic [8*PAT_BYTES-1:0] pat;
    pat = {pat_hi, pat_lo};
    return pat[8*i +: 8];
  endfunction

  // shift one byte in, then test the newest pat_len bytes against the pattern
  function automatic void scan_byte(in_item_t req);
    bit                        hit;
    logic [DEF_COUNT_BITS-1:0] start;
    if (!hit_done) begin
      for (int k = PAT_BYTES - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = req.data_byte;
      if (seen_cnt != '1) seen_cnt++;
      hit = pat_len != 0 && pat_len <= DEF_MAX_PATTERN && seen_cnt >= pat_len;
      if (hit) begin
        for (int i = 0; i < pat_len; i++)
          if (care_bits[i] && window[pat_len - 1 - i] != pat_byte(i)) hit = 1'b0;
      end
      if (hit) begin
        start = seen_cnt - pat_len;
        scan_verdicts.insert(scan_verdicts.size(),
                             out_item_t'{found: 1'b1,
                                         match_address: base_addr + ADDR_W'(start)});
        hit_done = 1'b1;
      end else if (req.last_byte) begin
        scan_verdicts.insert(scan_verdicts.size(),
                             out_item_t'{found: 1'b0, match_address: '0});
      end
    end
    if (req.last_byte) begin
      foreach (window[k]) window[k] = '0;
      seen_cnt = '0;
      hit_done = 1'b0;
    end
  endfunction

  // called just after a rising edge; the write lands at the next one
  task automatic write_reg(int idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_IDX_W'(idx);
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      REG_BASE:   base_addr = value;
      REG_PAT_LO: pat_lo = value;
      REG_PAT_HI: pat_hi = value;
      REG_CARE:   care_bits = value[PAT_BYTES-1:0];
      REG_LEN:    pat_len = value[LEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_setup(logic [63:0] base, logic [63:0] lo, logic [63:0] hi,
                            logic [63:0] care, logic [63:0] len);
    write_reg(REG_BASE, base);
    write_reg($urandom_range(TOP_IDX, SPARE_IDX), {$urandom, $urandom});
    write_reg(REG_PAT_LO, lo);
    write_reg(REG_PAT_HI, hi);
    write_reg(REG_CARE, care);
    write_reg(REG_LEN, len);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_setup();
    logic [63:0]          base;
    logic [PAT_BYTES-1:0] mask;
    logic [LEN_W-1:0]     len;
    case ($urandom_range(3, 0))
      0: base = '0;
      1: base = '1;
      2: base = {32'hFFFF_FFFF, $urandom};
      default: base = {$urandom, $urandom};
    endcase
    case ($urandom_range(3, 0))
      0: mask = '0;
      1: mask = '1;
      default: mask = PAT_BYTES'($urandom);
    endcase
    case ($urandom_range(9, 0))
      0: len = '0;
      1: len = LEN_W'($urandom_range(31, 17));
      2: len = LEN_W'(PAT_BYTES);
      default: len = LEN_W'($urandom_range(16, 1));
    endcase
    // junk in the unused upper bits must be dropped by the block
    load_setup(base, {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, 16'($urandom), mask}, {$urandom, 27'($urandom), len});
  endtask

  task automatic push_req(logic [7:0] data, bit last);
    pending_bytes.insert(pending_bytes.size(), in_item_t'{data_byte: data, last_byte: last});
    queued++;
  endtask

  // one range, biased towards pattern bytes, optionally with a planted match
  task automatic queue_range(int n, bit plant);
    logic [7:0] bytes [$];
    int         at;
    repeat (n)
      bytes.insert(bytes.size(),
                   $urandom_range(3, 0) == 0 ? pat_byte($urandom_range(PAT_BYTES - 1, 0))
                                             : 8'($urandom));
    if (plant && pat_len != 0 && pat_len <= DEF_MAX_PATTERN && n >= pat_len) begin
      at = $urandom_range(n - pat_len, 0);
      for (int i = 0; i < pat_len; i++)
        if (care_bits[i]) bytes[at + i] = pat_byte(i);
    end
    foreach (bytes[k]) push_req(bytes[k], k == n - 1);
  endtask

  task automatic drain();
    while (pending_bytes.size() != 0 || in_valid || scan_verdicts.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // sender: bursts of requests with gaps between them
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin : drive_requests
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) scan_byte(in_item);
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          in_item  <= pending_bytes.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(24, 1);
            case ($urandom_range(9, 0))
              0, 1, 2, 3: gap_left = 0;
              9: gap_left = $urandom_range(20, 8);
              default: gap_left = $urandom_range(4, 1);
            endcase
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern of its own, plus a long hold-off on request
  stall_mode_t stall_mode = FLOW;
  int          mode_left  = 0;
  int          hold_left  = 0;
  bit          hold_seen  = 1'b0;

  always @(posedge clk) begin : drive_stall
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_mode_t'($urandom_range(2, 0));
          mode_left  = $urandom_range(60, 10);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          FLOW:        out_stall <= 1'b0;
          SOME_STALLS: out_stall <= $urandom_range(3, 0) == 0;
          MANY_STALLS: out_stall <= $urandom_range(1, 0) == 0;
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (scan_verdicts.size() == 0) begin
        $display("%0t: unexpected result, expected none, got found=%0b address=%h",
                 $time, out_item.found, out_item.match_address);
        errors++;
      end else begin
        want = scan_verdicts.pop_front();
        if (out_item.found !== want.found) begin
          $display("%0t: found expected %0b, got %0b", $time, want.found, out_item.found);
          errors++;
        end
        if (out_item.match_address !== want.match_address) begin
          $display("%0t: match_address expected %h, got %h",
                   $time, want.match_address, out_item.match_address);
          errors++;
        end
      end
    end
  end

  initial begin : run_scans
    int rand_from;
    int target;
    int phase;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // length zero straight out of reset: never matches
    push_req(8'h00, 1'b0);
    push_req(8'hFF, 1'b1);
    drain();

    // three-byte pattern, middle byte don't-care; address wraps past the top
    load_setup(64'hFFFF_FFFF_FFFF_FFFE, 64'h0000_0000_00C3_5AA5, '1, 64'h5, 64'd3);
    push_req(8'h11, 1'b0);
    push_req(8'h22, 1'b0);
    push_req(8'hA5, 1'b0);
    push_req(8'h00, 1'b0);
    push_req(8'hC3, 1'b0);
    push_req(8'h77, 1'b0);
    push_req(8'h88, 1'b1);
    // match completed by the final byte
    push_req(8'hA5, 1'b0);
    push_req(8'h3C, 1'b0);
    push_req(8'hC3, 1'b1);
    // range shorter than the pattern
    push_req(8'hC3, 1'b1);
    drain();

    // all don't-care: matches as soon as the pattern fits in the range
    load_setup(64'h1000, '0, '0, '0, 64'd4);
    repeat (2) push_req(8'($urandom), 1'b0);
    push_req(8'($urandom), 1'b1);
    repeat (4) push_req(8'($urandom), 1'b0);
    push_req(8'($urandom), 1'b1);
    drain();

    // length beyond the window never matches
    load_setup('0, '1, '1, '1, 64'd31);
    push_req(8'hFF, 1'b0);
    push_req(8'hFF, 1'b1);
    drain();

    rand_from = queued;
    phase = 0;
    while (queued - rand_from < RANDOM_ITEMS) begin
      random_setup();
      if (phase == 2) hold_req <= ~hold_req;
      target = queued + $urandom_range(60, 30);
      while (queued < target)
        queue_range($urandom_range(7, 0) == 0 ? $urandom_range(50, 20) : $urandom_range(16, 1),
                    $urandom_range(4, 0) != 0);
      drain();
      phase++;
    end

    drain();
    if (errors == 0 && scan_verdicts.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #3ms;
    $display("FAILURE");
    $finish;
  end

endmodule
